// ===== rtl/skt_pkg.sv =====
// Shared types and constants of the sorted key table.
package skt_pkg;

  // Default number of table rows.
  localparam int CAPACITY_DEF = 16;

  // Fixed field widths of the item and result channels.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int TOTAL_W  = 7;

  // Command codes of an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  // Status codes of a result item.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_LIST
  } state_t;

  // One table row: key and five payload values.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] one;
    logic [VAL_W-1:0] two;
    logic [VAL_W-1:0] three;
    logic [VAL_W-1:0] four;
    logic [VAL_W-1:0] five;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic cap;         // capture compare flags against the item key
    logic load_new;    // take the new row from the item
    logic shift_up;    // take the row of the lower neighbor
    logic shift_down;  // take the row of the upper neighbor
  } cell_ctl_t;

endpackage

// ===== rtl/sorted_key_table_core.sv =====
// Top level of the sorted key table: sequencer, row cells and result register.
//
// The table holds up to CAPACITY rows sorted by ascending key. Items arrive on
// the in_ channel (valid/stall) and carry a command: insert, delete, lookup or
// list. Results leave on the out_ channel (valid/stall), one per item except for
// list: one result per held row, out_last on the last, or one STAT_EMPTY if empty.
//
// Each item passes the compare state, in which every cell compares its key with the
// item key, and then the shift state, in which the cells shift up or down and the
// result is loaded into the output register. The next item is taken in the cycle
// its result is loaded, so the block does not take a new item while one is still
// being compared, and a stalled receiver holds it back. A list then reads the held
// rows in order in the list state, one result per row.
//
// A stalled result holds in the output register; the block waits in the shift
// or list state until the register is free. Reset clears the entry count and the
// sequencer; row contents are not cleared and are never reported unless written.
module sorted_key_table_core #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [skt_pkg::CMD_W-1:0]     in_command,
  input  logic [skt_pkg::KEY_W-1:0]     in_key,
  input  logic [skt_pkg::VAL_W-1:0]     in_value_one,
  input  logic [skt_pkg::VAL_W-1:0]     in_value_two,
  input  logic [skt_pkg::VAL_W-1:0]     in_value_three,
  input  logic [skt_pkg::VAL_W-1:0]     in_value_four,
  input  logic [skt_pkg::VAL_W-1:0]     in_value_five,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [skt_pkg::STATUS_W-1:0]  out_status,
  output logic [skt_pkg::POS_W-1:0]     out_position,
  output logic [skt_pkg::KEY_W-1:0]     out_found_key,
  output logic [skt_pkg::VAL_W-1:0]     out_out_one,
  output logic [skt_pkg::VAL_W-1:0]     out_out_two,
  output logic [skt_pkg::VAL_W-1:0]     out_out_three,
  output logic [skt_pkg::VAL_W-1:0]     out_out_four,
  output logic [skt_pkg::VAL_W-1:0]     out_out_five,
  output logic [skt_pkg::TOTAL_W-1:0]   out_entry_total,
  output logic                          out_last
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef struct packed {
    skt_pkg::status_t             status;
    logic [skt_pkg::POS_W-1:0]    position;
    skt_pkg::entry_t              data;
    logic [skt_pkg::TOTAL_W-1:0]  total;
    logic                         last;
  } result_t;

  skt_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  skt_pkg::cmd_t     cmd_r;
  skt_pkg::entry_t   item_r;

  result_t           res;
  result_t           res_r;
  logic              out_valid_r;
  logic              emit;
  logic              do_ins;
  logic              do_del;

  logic              in_acc;
  logic              out_free;
  logic              finish;
  logic              list_more;
  logic              list_last;
  logic              full;
  logic              found;

  skt_pkg::cell_ctl_t  ctl      [CAPACITY];
  skt_pkg::entry_t     cell_ent [CAPACITY];
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;
  logic [CAPACITY-1:0] act_v;
  logic [CAPACITY-1:0] ge_v;
  logic [CAPACITY-1:0] bnd_v;

  logic [IDX_W-1:0]  pos_sel;
  skt_pkg::entry_t   sel_entry;
  skt_pkg::entry_t   list_entry;

  // Handshake terms.
  assign out_free  = !out_valid_r || !out_stall;
  assign list_more = (cmd_r == skt_pkg::CMD_LIST) && (count_r != '0);
  assign list_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign finish    = ((state_r == skt_pkg::S_EXEC) && out_free && !list_more) ||
                     ((state_r == skt_pkg::S_LIST) && out_free && list_last);
  assign in_stall  = !rst_n || !((state_r == skt_pkg::S_IDLE) || finish);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(CAPACITY));

  // Row cells: each compares its key and shifts with its neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_pkg::entry_t left_ent;
    skt_pkg::entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_ent = cell_ent[i];
    end else begin : g_inner_l
      assign left_ent = cell_ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign right_ent = cell_ent[i];
    end else begin : g_inner_r
      assign right_ent = cell_ent[i+1];
    end

    // Row holds a valid entry; row is at or after the key, or is the insert point.
    assign act_v[i] = (CNT_W'(i) < count_r);
    assign ge_v[i]  = !(lt_v[i] && act_v[i]);
    if (i == 0) begin : g_bnd0
      assign bnd_v[i] = ge_v[i];
    end else begin : g_bnd
      assign bnd_v[i] = ge_v[i] && !ge_v[i-1];
    end

    assign ctl[i].cap        = (state_r == skt_pkg::S_CMP);
    assign ctl[i].load_new   = do_ins && bnd_v[i];
    assign ctl[i].shift_up   = do_ins && ge_v[i] && !bnd_v[i];
    assign ctl[i].shift_down = do_del && ge_v[i];

    skt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .cmp_key     (item_r.key),
      .new_entry   (item_r),
      .left_entry  (left_ent),
      .right_entry (right_ent),
      .entry       (cell_ent[i]),
      .lt          (lt_v[i]),
      .eq          (eq_v[i])
    );
  end

  assign found = |(bnd_v & eq_v & act_v);

  // Encode the insert point and pick the rows for the boundary and the list.
  always_comb begin
    pos_sel    = '0;
    sel_entry  = '0;
    list_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd_v[i]) begin
        pos_sel   = pos_sel | IDX_W'(i);
        sel_entry = skt_pkg::entry_t'(sel_entry | cell_ent[i]);
      end
      if (idx_r == IDX_W'(i)) begin
        list_entry = skt_pkg::entry_t'(list_entry | cell_ent[i]);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_acc) state_nxt = skt_pkg::S_CMP;
      end
      skt_pkg::S_CMP: begin
        state_nxt = skt_pkg::S_EXEC;
      end
      skt_pkg::S_EXEC: begin
        if (list_more) begin
          state_nxt = skt_pkg::S_LIST;
        end else if (finish) begin
          state_nxt = in_acc ? skt_pkg::S_CMP : skt_pkg::S_IDLE;
        end
      end
      skt_pkg::S_LIST: begin
        if (finish) state_nxt = in_acc ? skt_pkg::S_CMP : skt_pkg::S_IDLE;
      end
      default: state_nxt = skt_pkg::S_IDLE;
    endcase
  end

  // Result forming, table update and list index.
  always_comb begin
    res       = '0;
    emit      = 1'b0;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    res.last  = 1'b1;
    case (state_r)
      skt_pkg::S_EXEC: begin
        idx_nxt = '0;
        if (out_free) begin
          case (cmd_r)
            skt_pkg::CMD_LIST: begin
              // Only an empty table gives a result here.
              emit       = (count_r == '0);
              res.status = skt_pkg::STAT_EMPTY;
            end
            skt_pkg::CMD_INSERT: begin
              emit         = 1'b1;
              res.data.key = item_r.key;
              if (found) begin
                res.status   = skt_pkg::STAT_DUP;
                res.position = skt_pkg::POS_W'(pos_sel);
                res.data     = sel_entry;
              end else if (full) begin
                res.status   = skt_pkg::STAT_FULL;
              end else begin
                do_ins       = 1'b1;
                count_nxt    = count_r + CNT_W'(1);
                res.status   = skt_pkg::STAT_OK;
                res.position = skt_pkg::POS_W'(pos_sel);
                res.data     = item_r;
              end
            end
            default: begin
              // Delete and lookup.
              emit         = 1'b1;
              res.data.key = item_r.key;
              if (count_r == '0) begin
                res.status = skt_pkg::STAT_EMPTY;
              end else if (!found) begin
                res.status = skt_pkg::STAT_NOTFOUND;
              end else begin
                res.status   = skt_pkg::STAT_OK;
                res.position = skt_pkg::POS_W'(pos_sel);
                res.data     = sel_entry;
                res.data.key = item_r.key;
                if (cmd_r == skt_pkg::CMD_DELETE) begin
                  do_del    = 1'b1;
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
          endcase
        end
      end
      skt_pkg::S_LIST: begin
        if (out_free) begin
          emit         = 1'b1;
          res.status   = skt_pkg::STAT_OK;
          res.position = skt_pkg::POS_W'(idx_r);
          res.data.key = list_entry.key;
          res.last     = list_last;
          idx_nxt      = idx_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
    res.total = skt_pkg::TOTAL_W'(count_nxt);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r        <= skt_pkg::cmd_t'(in_command);
      item_r.key   <= in_key;
      item_r.one   <= in_value_one;
      item_r.two   <= in_value_two;
      item_r.three <= in_value_three;
      item_r.four  <= in_value_four;
      item_r.five  <= in_value_five;
    end
    if (emit) begin
      res_r <= res;
    end
  end

  // Result ports.
  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_position    = res_r.position;
  assign out_found_key   = res_r.data.key;
  assign out_out_one     = res_r.data.one;
  assign out_out_two     = res_r.data.two;
  assign out_out_three   = res_r.data.three;
  assign out_out_four    = res_r.data.four;
  assign out_out_five    = res_r.data.five;
  assign out_entry_total = res_r.total;
  assign out_last        = res_r.last;

  // The entry count stays within the table.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // At most one cell marks the insert point.
  a_bnd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skt_pkg::S_EXEC) |-> $onehot0(bnd_v))
    else $error("more than one insert point");

  // The count changes only in the shift cycle.
  a_count_when: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> ($past(state_r) == skt_pkg::S_EXEC))
    else $error("entry count changed outside the shift cycle");

  // A result appears only after a shift or list cycle.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |->
      (($past(state_r) == skt_pkg::S_EXEC) || ($past(state_r) == skt_pkg::S_LIST)))
    else $error("result without a finished item");

endmodule

// ===== rtl/skt_cell.sv =====
// One row cell of the sorted key table: row storage, key compare and neighbor shift.
module skt_cell (
  input  logic                        clk,
  input  skt_pkg::cell_ctl_t          ctl,
  input  logic [skt_pkg::KEY_W-1:0]   cmp_key,
  input  skt_pkg::entry_t             new_entry,
  input  skt_pkg::entry_t             left_entry,
  input  skt_pkg::entry_t             right_entry,
  output skt_pkg::entry_t             entry,
  output logic                        lt,
  output logic                        eq
);

  skt_pkg::entry_t entry_r, entry_nxt;
  logic            lt_r, eq_r;

  // Select the row this cell holds after the current cycle.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_new) begin
      entry_nxt = new_entry;
    end else if (ctl.shift_up) begin
      entry_nxt = left_entry;
    end else if (ctl.shift_down) begin
      entry_nxt = right_entry;
    end
  end

  // Row storage and registered compare flags.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cap) begin
      lt_r <= (entry_r.key < cmp_key);
      eq_r <= (entry_r.key == cmp_key);
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule
